// File: design/mhf_pkg.sv
// mhf_pkg: shared types, constants and the cordic angle table for the
// magnetometer heading filter; no dependencies
`default_nettype none

package mhf_pkg;

    // fixed-point configuration
    localparam int CORDIC_STEPS     = 16;
    localparam int FILTER_FRAC_BITS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam int F_W     = 16 + FILTER_FRAC_BITS;   // filter state width
    localparam int DIFF_W  = F_W + 1;
    localparam int PROD_W  = DIFF_W + 17;
    localparam int CW      = 46;                      // cordic x / y width
    localparam int Z_W     = 26;                      // angle accumulator width
    localparam int H_W     = 18;
    localparam int ITER_W  = $clog2(ATAN_ENTRIES);
    localparam int NORM_STEPS = 6;                    // shifts of 32, 16, 8, 4, 2, 1
    localparam int NORM_W  = $clog2(NORM_STEPS);
    localparam int NORM_LIMIT = 40;                   // normalize, with the final doubling, to at least 2^40

    localparam logic [15:0] GAIN_RESET   = 16'd655;
    localparam logic [15:0] HEADING_MID  = 16'd23040;
    localparam logic [15:0] HEADING_MAX  = 16'd46080;
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 * 65536);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // burst positions
    localparam logic [2:0] POS_X_LO = 3'd1;
    localparam logic [2:0] POS_Z_LO = 3'd3;
    localparam logic [2:0] POS_Y_LO = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } t_sample;

    typedef struct packed {
        logic        [15:0] heading;
        logic signed [15:0] filtered_x;
        logic signed [15:0] filtered_y;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } t_result;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_LOAD,
        B_NORM,
        B_ROT,
        B_ITER,
        B_DONE
    } t_back_state;

    // atan(2^-i) in degrees, q16, rounded to nearest
    function automatic logic [21:0] f_atan(input logic [ITER_W-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234378;
            5'd5:    v = 22'd117305;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/mhf_front.sv
// mhf_front: byte assembly of the six-byte burst into one sample
// depends on mhf_pkg
`default_nettype none

module mhf_front
    import mhf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_push,
    output t_sample       o_sample
);

    logic [2:0]         r_pos, n_pos;
    logic [7:0]         r_hold;
    logic signed [15:0] r_held_x;
    logic signed [15:0] r_held_z;
    logic [2:0]         w_pos;
    logic signed [15:0] w_word;

    always_comb begin
        w_pos = i_item.frame_start ? 3'd0 : r_pos;
        if (w_pos > POS_Y_LO) begin
            w_pos = 3'd0;
        end
        n_pos  = (w_pos == POS_Y_LO) ? 3'd0 : w_pos + 3'd1;
        w_word = $signed({r_hold, i_item.data_byte});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hold   <= '0;
            r_held_x <= '0;
            r_held_z <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            case (w_pos)
                POS_X_LO: r_held_x <= w_word;
                POS_Z_LO: r_held_z <= w_word;
                POS_Y_LO: ;
                default:  r_hold <= i_item.data_byte;
            endcase
        end
    end

    assign o_push         = i_accept && (w_pos == POS_Y_LO);
    assign o_sample.raw_x = r_held_x;
    assign o_sample.raw_y = w_word;
    assign o_sample.raw_z = r_held_z;

endmodule

`default_nettype wire

// File: design/mhf_queue.sv
// mhf_queue: short sample queue between the front and the back
// depends on mhf_pkg
`default_nettype none

module mhf_queue
    import mhf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_sample i_sample,
    output logic         o_full,
    output logic         o_empty,
    input  wire logic    i_pop,
    output t_sample      o_sample
);

    t_sample              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty  = (r_count == '0);
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_pop && !o_empty;
    assign o_sample = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/mhf_back.sv
// mhf_back: low-pass filter update, iterative cordic heading and result register
// depends on mhf_pkg
`default_nettype none

module mhf_back
    import mhf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_gain,
    input  wire logic        i_q_empty,
    input  wire t_sample     i_sample,
    output logic             o_q_pop,
    output logic             o_empty,
    input  wire logic        i_pop,
    output t_result          o_result
);

    t_back_state              r_state, n_state;
    t_sample                  r_samp;
    logic signed [F_W-1:0]    r_fx, r_fy;
    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;
    logic signed [CW-1:0]     r_cx, r_cy;
    logic [CW-1:0]            r_m;
    logic signed [Z_W-1:0]    r_z;
    logic [NORM_W-1:0]        r_nstep;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_out_valid;
    t_result                  r_out;
    logic                     w_out_load;

    // filter datapath
    logic signed [DIFF_W-1:0] w_diff_x, w_diff_y;
    logic signed [PROD_W-1:0] w_step_x, w_step_y;
    logic signed [16:0]       w_gain_s;

    // cordic datapath
    logic                     w_zero;
    logic signed [CW-1:0]     w_ex, w_ey, w_ax, w_ay;
    logic [5:0]               w_k;
    logic [6:0]               w_lim;
    logic                     w_do_shift;
    logic signed [CW-1:0]     w_x2, w_y2;
    logic signed [CW-1:0]     w_dx, w_dy;
    logic signed [Z_W-1:0]    w_atan;
    logic signed [Z_W-1:0]    w_zr;
    logic signed [H_W-1:0]    w_hs;
    logic [15:0]              w_heading;

    always_comb begin
        w_gain_s = $signed({1'b0, i_gain});
        w_diff_x = $signed({r_samp.raw_x, {FILTER_FRAC_BITS{1'b0}}}) - DIFF_W'(r_fx);
        w_diff_y = $signed({r_samp.raw_y, {FILTER_FRAC_BITS{1'b0}}}) - DIFF_W'(r_fy);
        w_step_x = (r_prod_x + PROD_W'(32768)) >>> 16;
        w_step_y = (r_prod_y + PROD_W'(32768)) >>> 16;
    end

    always_comb begin
        w_zero = (r_fx == '0) && (r_fy == '0);
        w_ex   = CW'(r_fy);
        w_ey   = CW'(r_fx);
        w_ax   = (w_ex < 0) ? -w_ex : w_ex;
        w_ay   = (w_ey < 0) ? -w_ey : w_ey;
        // greedy shift search: 32, 16, 8, 4, 2, 1
        w_k        = 6'd32 >> r_nstep;
        w_lim      = 7'(NORM_LIMIT) - {1'b0, w_k};
        w_do_shift = ((r_m >> w_lim) == '0);
        // last doubling lifts the magnitude to at least 2^40
        w_x2 = r_cx <<< 1;
        w_y2 = r_cy <<< 1;
        w_dx = r_cy >>> r_iter;
        w_dy = r_cx >>> r_iter;
        w_atan = $signed({{(Z_W - 22){1'b0}}, f_atan(r_iter)});
        w_zr   = (r_z + Z_W'(256)) >>> 9;
        w_hs   = H_W'(w_zr) + $signed({{(H_W - 16){1'b0}}, HEADING_MID});
        if (w_hs < 0) begin
            w_heading = '0;
        end else if (w_hs > $signed({{(H_W - 16){1'b0}}, HEADING_MAX})) begin
            w_heading = HEADING_MAX;
        end else begin
            w_heading = w_hs[15:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_MUL;
            B_MUL:  n_state = B_ACC;
            B_ACC:  n_state = B_LOAD;
            B_LOAD: n_state = w_zero ? B_DONE : B_NORM;
            B_NORM: if (r_nstep == NORM_W'(NORM_STEPS - 1)) n_state = B_ROT;
            B_ROT:  n_state = B_ITER;
            B_ITER: if (r_iter == ITER_W'(CORDIC_N - 1)) n_state = B_DONE;
            B_DONE: if (!r_out_valid) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            B_IDLE:  o_q_pop    = !i_q_empty;
            B_DONE:  w_out_load = !r_out_valid;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_fx        <= '0;
            r_fy        <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == B_ACC) begin
                r_fx <= r_fx + w_step_x[F_W-1:0];
                r_fy <= r_fy + w_step_y[F_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_samp <= i_sample;
            end
            B_MUL: begin
                r_prod_x <= w_diff_x * w_gain_s;
                r_prod_y <= w_diff_y * w_gain_s;
            end
            B_LOAD: begin
                r_cx    <= w_ex;
                r_cy    <= w_ey;
                r_m     <= (w_ax > w_ay) ? w_ax : w_ay;
                r_z     <= '0;
                r_nstep <= '0;
            end
            B_NORM: begin
                r_nstep <= r_nstep + 1'b1;
                if (w_do_shift) begin
                    r_cx <= r_cx <<< w_k;
                    r_cy <= r_cy <<< w_k;
                    r_m  <= r_m << w_k;
                end
            end
            B_ROT: begin
                r_iter <= '0;
                if (w_x2 < 0) begin
                    if (w_y2 >= 0) begin
                        r_cx <= w_y2;
                        r_cy <= -w_x2;
                        r_z  <= Z_QUARTER;
                    end else begin
                        r_cx <= -w_y2;
                        r_cy <= w_x2;
                        r_z  <= -Z_QUARTER;
                    end
                end else begin
                    r_cx <= w_x2;
                    r_cy <= w_y2;
                    r_z  <= '0;
                end
            end
            B_ITER: begin
                r_iter <= r_iter + 1'b1;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_z  <= r_z + w_atan;
                end else begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_z  <= r_z - w_atan;
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out.heading    <= w_heading;
            r_out.filtered_x <= r_fx[FILTER_FRAC_BITS+15:FILTER_FRAC_BITS];
            r_out.filtered_y <= r_fy[FILTER_FRAC_BITS+15:FILTER_FRAC_BITS];
            r_out.raw_x      <= r_samp.raw_x;
            r_out.raw_y      <= r_samp.raw_y;
            r_out.raw_z      <= r_samp.raw_z;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: design/magnetometer_heading_filter_core.sv
// magnetometer_heading_filter_core: top level, byte front, sample queue, filter
// and cordic back; depends on mhf_pkg, mhf_front, mhf_queue, mhf_back
//
//  channel   ports                          moves
//  input     i_push, o_full, i_item         one burst byte and frame start flag
//  result    o_empty, i_pop, o_result       heading, filtered and raw samples
//  config    i_cfg_we, i_cfg_data           filter gain, q0.16
//
// a byte is taken every cycle while the two-entry sample queue has room
// the sixth byte of a burst queues a sample; the back then runs queue pop, two filter
// steps (multiply, accumulate), load, six normalize shifts, pre-rotation, CORDIC_N
// cordic steps and the result write, and takes no new sample until it is done
// with both filters at zero the normalize, pre-rotation and cordic steps are skipped
// the back holds in its last state while the result register is still full
// synchronous active-low reset clears burst position, held bytes, queue, filters; gain to GAIN_RESET
`default_nettype none

module magnetometer_heading_filter_core
    import mhf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input, queue style
    input  wire logic        i_push,
    input  wire t_in_item    i_item,
    output logic             o_full,
    // result output, queue style
    output logic             o_empty,
    input  wire logic        i_pop,
    output t_result          o_result,
    // gain register
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_gain;
    logic        w_accept;
    logic        w_f_push;
    t_sample     w_f_sample;
    logic        w_q_empty;
    logic        w_q_pop;
    t_sample     w_q_sample;

    // gain register, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_data;
        end
    end

    // full stalls every byte, so a sixth byte always finds a free entry
    assign w_accept = i_push && !o_full;

    mhf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_f_push),
        .o_sample (w_f_sample)
    );

    // decouples byte intake from the long per-sample back end
    mhf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_f_push),
        .i_sample (w_f_sample),
        .o_full   (o_full),
        .o_empty  (w_q_empty),
        .i_pop    (w_q_pop),
        .o_sample (w_q_sample)
    );

    // filters run in sample order, so state updates match the burst order
    mhf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gain    (r_gain),
        .i_q_empty (w_q_empty),
        .i_sample  (w_q_sample),
        .o_q_pop   (w_q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
// tb: self-checking testbench for magnetometer_heading_filter_core, byte bursts in,
// heading and filtered samples out, checked against an in-bench fixed-point predictor
// depends on mhf_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
    import mhf_pkg::*;

    localparam int SETTLE = 2 * (CORDIC_N + 12) + 8;   // back latency with margin
    localparam int LIMIT  = 400000;                    // cycle budget for the whole run

    // one row of the directed table: a byte, its frame start flag and,
    // where it is obvious, the result that the byte must produce
    typedef struct packed {
        logic [7:0] b;
        logic       fs;
        logic       typed;
        t_result    want;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_push     = 1'b0;
    t_in_item    i_item     = '0;
    logic        o_full;
    logic        o_empty;
    logic        i_pop      = 1'b0;
    t_result     o_result;
    logic        i_cfg_we   = 1'b0;
    logic [15:0] i_cfg_data = '0;

    magnetometer_heading_filter_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .o_full     (o_full),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state: burst tracking, two filters in q16.16, current gain
    logic [2:0]         burst_pos = '0;
    logic [7:0]         hi_hold   = '0;
    logic signed [15:0] x_hold    = '0;
    logic signed [15:0] z_hold    = '0;
    longint             fx_acc    = 0;
    longint             fy_acc    = 0;
    logic [15:0]        gain_q16  = GAIN_RESET;

    // atan(2^-i) in degrees scaled by 2^16
    longint atan_q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234378, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    t_result want_q [$];          // results still owed by the core, oldest first
    int      err_count     = 0;
    int      items_sent    = 0;
    int      cycle_count   = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    t_result head_r;

    // directed table: zero burst after reset, top-end heading, full-scale
    // extremes, and a stray byte that a frame start has to recover from
    t_row dir_rows [25] = '{
        // all-zero burst at the reset gain, frame start already on position zero
        {8'h00, 1'b1, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b1, HEADING_MID, 80'h0},
        // x zero, z full positive, y full negative: filtered y below zero
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h7f, 1'b0, 1'b0, 96'h0},
        {8'hff, 1'b0, 1'b0, 96'h0},
        {8'h80, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        // x and y full positive, z full negative
        {8'h7f, 1'b0, 1'b0, 96'h0},
        {8'hff, 1'b0, 1'b0, 96'h0},
        {8'h80, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h7f, 1'b0, 1'b0, 96'h0},
        {8'hff, 1'b0, 1'b0, 96'h0},
        // stray byte knocks the position off, frame start pulls it back
        {8'ha5, 1'b0, 1'b0, 96'h0},
        {8'h80, 1'b1, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'hff, 1'b0, 1'b0, 96'h0},
        {8'hff, 1'b0, 1'b0, 96'h0},
        {8'h00, 1'b0, 1'b0, 96'h0},
        {8'h01, 1'b0, 1'b0, 96'h0}
    };

    // one low-pass step: f += round_half_up((raw - f) * gain / 2^16)
    function automatic longint lp_step(longint f, logic signed [15:0] raw, logic [15:0] g);
        longint d;
        d = (longint'(raw) <<< FILTER_FRAC_BITS) - f;
        return f + ((d * longint'(g) + 32768) >>> 16);
    endfunction

    // vectoring cordic on (filtered y, filtered x), angle in degrees * 2^16,
    // then moved to 1/128 degree with 180 degrees added
    function automatic logic [15:0] heading_of(longint fx, longint fy);
        longint cx, cy, ang, mag, dx, dy, t, h;
        cx  = fy;
        cy  = fx;
        ang = 0;
        // both filters at zero: defined as straight 180 degrees
        if (cx == 0 && cy == 0)
            return HEADING_MID;
        mag = (cx < 0) ? -cx : cx;
        if (((cy < 0) ? -cy : cy) > mag)
            mag = (cy < 0) ? -cy : cy;
        // normalize so the larger magnitude sits at or above 2^40
        while (mag < (longint'(1) <<< NORM_LIMIT)) begin
            cx  = cx * 2;
            cy  = cy * 2;
            mag = mag * 2;
        end
        // left half plane: pre-rotate a quarter turn into the right half
        if (cx < 0) begin
            t = cx;
            if (cy >= 0) begin
                cx  = cy;
                cy  = -t;
                ang = 90 * 65536;
            end else begin
                cx  = -cy;
                cy  = t;
                ang = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx  = cx + dx;
                cy  = cy - dy;
                ang = ang + atan_q16[i];
            end else begin
                cx  = cx - dx;
                cy  = cy + dy;
                ang = ang - atan_q16[i];
            end
        end
        h = ((ang + 256) >>> 9) + 23040;
        if (h < 0)
            h = 0;
        if (h > 46080)
            h = 46080;
        return 16'(h);
    endfunction

    // advance the burst tracker by one accepted byte; a result comes out on y lo
    task automatic absorb_byte(input logic [7:0] b, input logic fs,
                               output bit made, output t_result r);
        logic [2:0]         pos;
        logic signed [15:0] ry;
        pos  = fs ? 3'd0 : burst_pos;
        if (pos > POS_Y_LO)
            pos = 3'd0;
        burst_pos = (pos == POS_Y_LO) ? 3'd0 : pos + 3'd1;
        made = 1'b0;
        r    = '0;
        case (pos)
            POS_X_LO: x_hold = {hi_hold, b};
            POS_Z_LO: z_hold = {hi_hold, b};
            POS_Y_LO: begin
                ry     = {hi_hold, b};
                fx_acc = lp_step(fx_acc, x_hold, gain_q16);
                fy_acc = lp_step(fy_acc, ry, gain_q16);
                r.heading    = heading_of(fx_acc, fy_acc);
                r.filtered_x = 16'(fx_acc >>> FILTER_FRAC_BITS);
                r.filtered_y = 16'(fy_acc >>> FILTER_FRAC_BITS);
                r.raw_x      = x_hold;
                r.raw_y      = ry;
                r.raw_z      = z_hold;
                made = 1'b1;
            end
            default: hi_hold = b;
        endcase
    endtask

    // offer one byte, with random idle cycles ahead of it, and wait until taken
    task automatic push_byte(input logic [7:0] b, input logic fs,
                             input logic typed, input t_result typed_res);
        bit      made;
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= {b, fs};
        do begin
            @(posedge i_clk);
        end while (o_full);
        absorb_byte(b, fs, made, r);
        if (made)
            want_q.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // sample values: full-scale ends, values around zero, anything
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // first n bytes of a burst with random x, z, y words
    task automatic send_burst(input int n_bytes, input logic first_fs);
        logic [7:0]  seq [6];
        logic [15:0] w;
        for (int k = 0; k < 3; k++) begin
            w          = pick_word();
            seq[2*k]   = w[15:8];
            seq[2*k+1] = w[7:0];
        end
        for (int k = 0; k < n_bytes; k++)
            push_byte(seq[k], (k == 0) ? first_fs : 1'b0, 1'b0, '0);
    endtask

    // mostly well-formed bursts, some cut short, some stray bytes
    task automatic run_chunk(input int n_items);
        int stop_at;
        int n;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0: begin
                    n = $urandom_range(4, 1);
                    for (int k = 0; k < n; k++)
                        push_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, '0);
                end
                1:       send_burst($urandom_range(5, 1), 1'b1);
                default: send_burst(6, $urandom_range(3) != 0);
            endcase
        end
    endtask

    // stop offering, let every owed result come back, then let the back settle
    task automatic drain();
        i_push <= 1'b0;
        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // gain write, only ever issued while the core is idle
    task automatic set_gain(input logic [15:0] g);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gain_q16 = g;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected 0x%h actual 0x%h", $time, name, want, got);
            err_count++;
        end
    endtask

    // result side: check every popped item against the oldest expectation,
    // then pick the next pop value at random
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (want_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual 0x%h", $time, o_result);
                err_count++;
            end else begin
                head_r = want_q.pop_front();
                check_field("heading",    head_r.heading,    o_result.heading);
                check_field("filtered_x", head_r.filtered_x, o_result.filtered_x);
                check_field("filtered_y", head_r.filtered_y, o_result.filtered_y);
                check_field("raw_x",      head_r.raw_x,      o_result.raw_x);
                check_field("raw_y",      head_r.raw_y,      o_result.raw_y);
                check_field("raw_z",      head_r.raw_z,      o_result.raw_z);
            end
        end
        i_pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset gain, slow sender and slower receiver
        send_idle_pct = 19;
        recv_idle_pct = 60;
        foreach (dir_rows[n])
            push_byte(dir_rows[n].b, dir_rows[n].fs, dir_rows[n].typed, dir_rows[n].want);
        drain();

        // largest gain: filters follow the raw samples almost at once
        set_gain(16'hffff);
        run_chunk(112);
        drain();

        // smallest gain, idling the other way round
        send_idle_pct = 60;
        recv_idle_pct = 19;
        set_gain(16'd1);
        run_chunk(112);
        drain();

        // half gain, then a random gain, both sides at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_gain(16'h8000);
        run_chunk(112);
        drain();

        set_gain(16'($urandom_range(65535, 1)));
        run_chunk(114);
        drain();

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/mhf_pkg.sv
design/mhf_front.sv
design/mhf_queue.sv
design/mhf_back.sv
design/magnetometer_heading_filter_core.sv
dv/tb.sv
